// File: sv/tdsrtp_pkg.sv
// shared types, codes and helpers for the response token parser
package tdsrtp_pkg;

  // token codes
  localparam logic [7:0] TOK_ERROR      = 8'hAA;
  localparam logic [7:0] TOK_DONE       = 8'hFD;
  localparam logic [7:0] TOK_DONEPROC   = 8'hFE;
  localparam logic [7:0] TOK_DONEINPROC = 8'hFF;
  localparam logic [7:0] TOK_INFO       = 8'hAB;
  localparam logic [7:0] TOK_ENVCHANGE  = 8'hE3;

  // done status bit that flags an error
  localparam int unsigned STATUS_ERR_BIT = 1;

  // input item kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_EOM  = 1'b1;

  // outcome codes
  localparam logic [1:0] OUTCOME_CONFIRMED = 2'd0;
  localparam logic [1:0] OUTCOME_ERROR     = 2'd1;
  localparam logic [1:0] OUTCOME_NO_DONE   = 2'd2;

  // last and first byte indices of fixed fields
  localparam logic [3:0] ERR_HEAD_LAST = 4'd7;
  localparam logic [3:0] ERR_LINE_LAST = 4'd3;
  localparam logic [3:0] DONE_LAST     = 4'd11;
  localparam int unsigned DONE_ROWS_FIRST = 4;

  typedef enum logic [3:0] {
    PH_TOKEN      = 4'd0,
    PH_ERR_HEAD   = 4'd1,
    PH_ERR_MSGLEN = 4'd2,
    PH_ERR_MSG    = 4'd3,
    PH_ERR_SRVLEN = 4'd4,
    PH_ERR_SRV    = 4'd5,
    PH_ERR_PRCLEN = 4'd6,
    PH_ERR_PRC    = 4'd7,
    PH_ERR_LINE   = 4'd8,
    PH_DONE       = 4'd9,
    PH_LEN        = 4'd10,
    PH_SKIP       = 4'd11
  } phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] reply_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [63:0] row_count;
    logic        done_found;
    logic        error_found;
    logic        truncated;
  } out_t;

  // field that follows a skipped run of bytes
  function automatic phase_t phase_after_skip(phase_t ph);
    phase_t res;
    res = PH_TOKEN;
    unique case (ph)
      PH_ERR_MSG: res = PH_ERR_SRVLEN;
      PH_ERR_SRV: res = PH_ERR_PRCLEN;
      PH_ERR_PRC: res = PH_ERR_LINE;
      default:    res = PH_TOKEN;
    endcase
    return res;
  endfunction

  // phase entered when a skip of cnt bytes starts
  function automatic phase_t begin_skip(phase_t ph, logic [16:0] cnt);
    phase_t res;
    res = (cnt == 17'd0) ? phase_after_skip(ph) : ph;
    return res;
  endfunction

endpackage

// File: sv/tds_response_token_parser.sv
// token stream parser for the reply that ends a bulk load
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | input     | in_valid / in_stall | in_data  (func, reply_byte)
//  out     | output    | out_valid/out_stall | out_data (outcome, rows, flags)
//
// one item per cycle while in_stall is low: an input register, the field state machine
// logic, and a result register.
// the byte state machine and its 64-bit row assembly lie between the two registers.
// reset (rst_n low, synchronous) empties both registers and the parser state.
// in_stall rises only when an end-of-message item waits behind a stalled result.
module tds_response_token_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tdsrtp_pkg::in_t     in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tdsrtp_pkg::out_t    out_data
);

  // input register
  logic                s1_valid_r, s1_valid_nxt;
  tdsrtp_pkg::in_t     s1_data_r;
  logic                s1_fire;
  logic                s1_eom;

  // parser state
  tdsrtp_pkg::phase_t  phase_r, phase_nxt;
  logic [16:0]         skip_r, skip_nxt;
  logic [3:0]          idx_r, idx_nxt;
  logic [7:0]          len_low_r, len_low_nxt;
  logic                stat_err_r, stat_err_nxt;
  logic [63:0]         pend_rows_r, pend_rows_nxt;
  logic [63:0]         rows_r, rows_nxt;
  logic                done_r, done_nxt;
  logic                err_r, err_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  tdsrtp_pkg::out_t    out_data_r, out_data_nxt;

  logic [7:0]          b;
  logic [16:0]         cnt;
  logic [16:0]         skip_dec;

  // transfer control
  assign s1_eom   = s1_data_r.func == tdsrtp_pkg::FUNC_EOM;
  assign s1_fire  = s1_valid_r && (!s1_eom || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;
  assign s1_valid_nxt = (in_valid && !in_stall) ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign b = s1_data_r.reply_byte;
  assign skip_dec = (skip_r != 17'd0) ? (skip_r - 17'd1) : 17'd0;

  // field state machine
  always_comb begin
    phase_nxt     = phase_r;
    skip_nxt      = skip_r;
    idx_nxt       = idx_r;
    len_low_nxt   = len_low_r;
    stat_err_nxt  = stat_err_r;
    pend_rows_nxt = pend_rows_r;
    rows_nxt      = rows_r;
    done_nxt      = done_r;
    err_nxt       = err_r;
    cnt           = 17'd0;
    if (s1_fire && s1_eom) begin
      phase_nxt     = tdsrtp_pkg::PH_TOKEN;
      skip_nxt      = 17'd0;
      idx_nxt       = 4'd0;
      len_low_nxt   = 8'd0;
      stat_err_nxt  = 1'b0;
      pend_rows_nxt = 64'd0;
      rows_nxt      = 64'd0;
      done_nxt      = 1'b0;
      err_nxt       = 1'b0;
    end else if (s1_fire) begin
      unique case (phase_r)
        tdsrtp_pkg::PH_ERR_HEAD: begin
          if (idx_r == tdsrtp_pkg::ERR_HEAD_LAST) begin
            idx_nxt   = 4'd0;
            phase_nxt = tdsrtp_pkg::PH_ERR_MSGLEN;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
        tdsrtp_pkg::PH_ERR_MSGLEN: begin
          if (idx_r == 4'd0) begin
            len_low_nxt = b;
            idx_nxt     = 4'd1;
          end else begin
            // length is in characters, two bytes each
            cnt       = {b, len_low_r, 1'b0};
            idx_nxt   = 4'd0;
            skip_nxt  = cnt;
            phase_nxt = tdsrtp_pkg::begin_skip(tdsrtp_pkg::PH_ERR_MSG, cnt);
          end
        end
        tdsrtp_pkg::PH_ERR_SRVLEN: begin
          cnt       = {8'd0, b, 1'b0};
          idx_nxt   = 4'd0;
          skip_nxt  = cnt;
          phase_nxt = tdsrtp_pkg::begin_skip(tdsrtp_pkg::PH_ERR_SRV, cnt);
        end
        tdsrtp_pkg::PH_ERR_PRCLEN: begin
          cnt       = {8'd0, b, 1'b0};
          idx_nxt   = 4'd0;
          skip_nxt  = cnt;
          phase_nxt = tdsrtp_pkg::begin_skip(tdsrtp_pkg::PH_ERR_PRC, cnt);
        end
        tdsrtp_pkg::PH_ERR_LINE: begin
          if (idx_r == tdsrtp_pkg::ERR_LINE_LAST) begin
            idx_nxt   = 4'd0;
            phase_nxt = tdsrtp_pkg::PH_TOKEN;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
        tdsrtp_pkg::PH_DONE: begin
          // only the error bit of the status matters downstream
          if (idx_r == 4'd0) begin
            stat_err_nxt = b[tdsrtp_pkg::STATUS_ERR_BIT];
          end
          // little-endian row count, one lane per byte
          for (int k = 0; k < 8; k++) begin
            if (idx_r == 4'(k + tdsrtp_pkg::DONE_ROWS_FIRST)) begin
              pend_rows_nxt[8*k +: 8] = b;
            end
          end
          if (idx_r == tdsrtp_pkg::DONE_LAST) begin
            rows_nxt  = pend_rows_nxt;
            done_nxt  = 1'b1;
            err_nxt   = err_r | stat_err_r;
            idx_nxt   = 4'd0;
            phase_nxt = tdsrtp_pkg::PH_TOKEN;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
        tdsrtp_pkg::PH_LEN: begin
          if (idx_r == 4'd0) begin
            len_low_nxt = b;
            idx_nxt     = 4'd1;
          end else begin
            cnt       = {1'b0, b, len_low_r};
            idx_nxt   = 4'd0;
            skip_nxt  = cnt;
            phase_nxt = tdsrtp_pkg::begin_skip(tdsrtp_pkg::PH_SKIP, cnt);
          end
        end
        tdsrtp_pkg::PH_ERR_MSG, tdsrtp_pkg::PH_ERR_SRV,
        tdsrtp_pkg::PH_ERR_PRC, tdsrtp_pkg::PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 17'd0) begin
            phase_nxt = tdsrtp_pkg::phase_after_skip(phase_r);
          end
        end
        default: begin
          // token byte
          idx_nxt = 4'd0;
          if (b == tdsrtp_pkg::TOK_ERROR) begin
            err_nxt   = 1'b1;
            phase_nxt = tdsrtp_pkg::PH_ERR_HEAD;
          end else if (b == tdsrtp_pkg::TOK_DONE || b == tdsrtp_pkg::TOK_DONEPROC ||
                       b == tdsrtp_pkg::TOK_DONEINPROC) begin
            stat_err_nxt  = 1'b0;
            pend_rows_nxt = 64'd0;
            phase_nxt     = tdsrtp_pkg::PH_DONE;
          end else begin
            // info, envchange and unknown tokens all carry a 16-bit length
            phase_nxt = tdsrtp_pkg::PH_LEN;
          end
        end
      endcase
    end
  end

  // result assembly
  always_comb begin
    out_data_nxt = out_data_r;
    if (s1_fire && s1_eom) begin
      if (err_r) begin
        out_data_nxt.outcome = tdsrtp_pkg::OUTCOME_ERROR;
      end else if (done_r) begin
        out_data_nxt.outcome = tdsrtp_pkg::OUTCOME_CONFIRMED;
      end else begin
        out_data_nxt.outcome = tdsrtp_pkg::OUTCOME_NO_DONE;
      end
      out_data_nxt.row_count   = rows_r;
      out_data_nxt.done_found  = done_r;
      out_data_nxt.error_found = err_r;
      out_data_nxt.truncated   = phase_r != tdsrtp_pkg::PH_TOKEN;
    end
  end

  assign out_valid_nxt = (s1_fire && s1_eom) ? 1'b1 :
                         (out_stall ? out_valid_r : 1'b0);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= tdsrtp_pkg::PH_TOKEN;
      skip_r      <= 17'd0;
      idx_r       <= 4'd0;
      len_low_r   <= 8'd0;
      stat_err_r  <= 1'b0;
      pend_rows_r <= 64'd0;
      rows_r      <= 64'd0;
      done_r      <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      skip_r      <= skip_nxt;
      idx_r       <= idx_nxt;
      len_low_r   <= len_low_nxt;
      stat_err_r  <= stat_err_nxt;
      pend_rows_r <= pend_rows_nxt;
      rows_r      <= rows_nxt;
      done_r      <= done_nxt;
      err_r       <= err_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/tdsrtp_checker.sv
// port-level checks for the response token parser, with its bind
module tdsrtp_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input tdsrtp_pkg::out_t out_data
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // outcome code is one of the three meaningful values
  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.outcome != 2'd3)
    else $error("outcome code out of range");

  // error outcome tracks the error flag
  a_err_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.error_found == (out_data.outcome == tdsrtp_pkg::OUTCOME_ERROR)))
    else $error("error flag and outcome disagree");

  // confirmed needs a completed done token
  a_confirmed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome == tdsrtp_pkg::OUTCOME_CONFIRMED |-> out_data.done_found)
    else $error("confirmed without done token");

  // no done token means no row count
  a_no_done_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.done_found |-> out_data.row_count == 64'd0)
    else $error("row count without done token");

endmodule

bind tds_response_token_parser tdsrtp_checker u_tdsrtp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
